### design/sab_pkg.sv
`timescale 1ns / 1ps
// package: sizes, payload types and address helpers for the suffix automaton builder
package sab_pkg;

  localparam int MAX_LEN  = 1024;
  localparam int ALPHABET = 26;
  localparam int NSTATES  = 2 * MAX_LEN;

  localparam int SW       = $clog2(NSTATES);          // state id width
  localparam int LW       = $clog2(MAX_LEN) + 1;      // length width
  localparam int POS_W    = $clog2(MAX_LEN);          // position index width
  localparam int SYM_W    = 5;
  localparam int TDEPTH   = NSTATES * ALPHABET;
  localparam int TADDR_W  = $clog2(TDEPTH);
  localparam int IADDR_W  = SW + 1;                   // states, then positions
  localparam int IDEPTH   = NSTATES + MAX_LEN;

  typedef enum logic [1:0] {
    OP_RESET  = 2'd0,
    OP_APPEND = 2'd1,
    OP_LOCATE = 2'd2
  } op_e;

  typedef struct packed {
    logic [1:0]  op;
    logic [4:0]  symbol;
    logic [10:0] end_pos;
    logic [10:0] sub_len;
  } in_t;

  typedef struct packed {
    logic [11:0] state_id;
    logic [10:0] state_longest;
    logic        error;
  } out_t;

  // per-state entry: longest length and suffix link; position entries use link
  typedef struct packed {
    logic [LW-1:0] len;
    logic [SW-1:0] link;
  } info_t;

  localparam int INFO_W = $bits(info_t);

  function automatic logic [TADDR_W-1:0] trow(logic [SW-1:0] s, logic [SYM_W-1:0] col);
    return TADDR_W'(32'(s) * ALPHABET + 32'(col));
  endfunction

  function automatic logic [IADDR_W-1:0] saddr(logic [SW-1:0] s);
    return {1'b0, s};
  endfunction

  function automatic logic [IADDR_W-1:0] paddr(logic [POS_W-1:0] pos);
    return {1'b1, {(IADDR_W - 1 - POS_W){1'b0}}, pos};
  endfunction

endpackage

### design/suffix_automaton_builder.sv
`timescale 1ns / 1ps
// Online suffix automaton builder over a 26-letter alphabet, one operation per word.
// Input channel (in_valid_i/in_ready_o/in_data_i) takes words: reset automaton, append
// symbol or locate substring state. Output channel (out_valid_o/out_ready_i/out_data_o)
// returns exactly one word per input word: state id, its longest length and an error flag.
// The block works on one word at a time; in_ready_o is high while the sequencer is idle.
// All work runs through two memories with registered reads: the transition table
// (one row of 26 entries per state) and the state info memory (length, suffix link and
// the per-position state table).
// A reset op clears the root row; an append clears the new state's row, walks suffix
// links and, when a state is cloned, copies a row of 26 entries; a locate follows suffix
// links from the state recorded for the end position; refused words go to the reply.
// Row clears and row copies make up most of the work.
// After rst_ni the root row is cleared with in_ready_o low.
// A finished result sits in the output register; the next word is accepted while it
// waits, and a second result waits in the sequencer until out_ready_i frees the register.
module suffix_automaton_builder (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  sab_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output sab_pkg::out_t out_data_o
);

  localparam int SW = sab_pkg::SW;
  localparam int LW = sab_pkg::LW;

  typedef enum logic [14:0] {
    S_IDLE     = 15'b000000000000001,
    S_CLR_ROOT = 15'b000000000000010,
    S_AP_RD    = 15'b000000000000100,
    S_AP_NEW   = 15'b000000000001000,
    S_AP_CLR   = 15'b000000000010000,
    S_AP_W1    = 15'b000000000100000,
    S_AP_QCHK  = 15'b000000001000000,
    S_AP_COPY  = 15'b000000010000000,
    S_AP_W2    = 15'b000000100000000,
    S_LC_RD    = 15'b000001000000000,
    S_LC_POS   = 15'b000010000000000,
    S_LC_CUR   = 15'b000100000000000,
    S_LC_CHK   = 15'b001000000000000,
    S_LC_FIN   = 15'b010000000000000,
    S_DONE     = 15'b100000000000000
  } state_e;

  state_e state_q, state_d;
  logic [4:0]    k_q, k_d;
  logic [SW-1:0] last_q, last_d, count_q, count_d;
  logic [LW-1:0] app_q, app_d;
  logic [SW-1:0] p_q, p_d, np_q, np_d, q_q, q_d, nq_q, nq_d;
  logic [SW-1:0] cur_q, cur_d, link_q, link_d;
  logic [LW-1:0] lennp_q, lennp_d, lenp_q, lenp_d, lenq_q, lenq_d, curlen_q, curlen_d;
  logic [4:0]    sym_q, sym_d;
  logic [10:0]   endpos_q, endpos_d, sublen_q, sublen_d;
  logic          init_reply_q, init_reply_d;
  sab_pkg::out_t res_q, res_d, out_q, out_d;
  logic          out_valid_q, out_valid_d;

  logic                        t_we;
  logic [sab_pkg::TADDR_W-1:0] t_waddr, t_raddr;
  logic [SW-1:0]               t_wdata, t_rdata;
  logic                        i_we;
  logic [sab_pkg::IADDR_W-1:0] i_waddr, i_raddr;
  sab_pkg::info_t              i_wdata, ir;
  logic [sab_pkg::INFO_W-1:0]  i_rdata;

  sab_ram #(
    .DW   (SW),
    .DEPTH(sab_pkg::TDEPTH),
    .AW   (sab_pkg::TADDR_W)
  ) u_trans (
    .clk_i  (clk_i),
    .we_i   (t_we),
    .waddr_i(t_waddr),
    .wdata_i(t_wdata),
    .raddr_i(t_raddr),
    .rdata_o(t_rdata)
  );

  sab_ram #(
    .DW   (sab_pkg::INFO_W),
    .DEPTH(sab_pkg::IDEPTH),
    .AW   (sab_pkg::IADDR_W)
  ) u_info (
    .clk_i  (clk_i),
    .we_i   (i_we),
    .waddr_i(i_waddr),
    .wdata_i(i_wdata),
    .raddr_i(i_raddr),
    .rdata_o(i_rdata)
  );

  assign ir = sab_pkg::info_t'(i_rdata);

  logic ap_err, lc_err;
  always_comb begin
    ap_err = (app_q >= LW'(sab_pkg::MAX_LEN)) ||
             (({1'b0, count_q} + (SW+1)'(2)) >= (SW+1)'(sab_pkg::NSTATES)) ||
             (in_data_i.symbol >= 5'(sab_pkg::ALPHABET));
    lc_err = (in_data_i.end_pos == 11'd0) || (in_data_i.end_pos > 11'(app_q)) ||
             (in_data_i.sub_len == 11'd0) || (in_data_i.sub_len > in_data_i.end_pos);
  end

  always_comb begin
    state_d      = state_q;
    k_d          = k_q;
    last_d       = last_q;
    count_d      = count_q;
    app_d        = app_q;
    p_d          = p_q;
    np_d         = np_q;
    q_d          = q_q;
    nq_d         = nq_q;
    cur_d        = cur_q;
    link_d       = link_q;
    lennp_d      = lennp_q;
    lenp_d       = lenp_q;
    lenq_d       = lenq_q;
    curlen_d     = curlen_q;
    sym_d        = sym_q;
    endpos_d     = endpos_q;
    sublen_d     = sublen_q;
    init_reply_d = init_reply_q;
    res_d        = res_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q & ~out_ready_i;
    t_we    = 1'b0;
    t_waddr = '0;
    t_wdata = '0;
    t_raddr = '0;
    i_we    = 1'b0;
    i_waddr = '0;
    i_wdata = '0;
    i_raddr = '0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          res_d   = '{state_id: 12'd0, state_longest: 11'd0, error: 1'b1};
          state_d = S_DONE;
          case (in_data_i.op)
            sab_pkg::OP_RESET: begin
              last_d       = SW'(1);
              count_d      = SW'(1);
              app_d        = '0;
              init_reply_d = 1'b1;
              k_d          = '0;
              res_d        = '{state_id: 12'd1, state_longest: 11'd0, error: 1'b0};
              state_d      = S_CLR_ROOT;
            end
            sab_pkg::OP_APPEND: begin
              if (!ap_err) begin
                sym_d   = in_data_i.symbol;
                state_d = S_AP_RD;
              end
            end
            sab_pkg::OP_LOCATE: begin
              if (!lc_err) begin
                endpos_d = in_data_i.end_pos;
                sublen_d = in_data_i.sub_len;
                state_d  = S_LC_RD;
              end
            end
            default: ;
          endcase
        end
      end
      S_CLR_ROOT: begin
        t_we    = 1'b1;
        t_waddr = sab_pkg::trow(SW'(1), k_q);
        if (k_q == 5'd0) begin
          i_we    = 1'b1;
          i_waddr = sab_pkg::saddr(SW'(0));
        end else if (k_q == 5'd1) begin
          i_we    = 1'b1;
          i_waddr = sab_pkg::saddr(SW'(1));
        end
        if (k_q == 5'(sab_pkg::ALPHABET - 1)) begin
          state_d      = init_reply_q ? S_DONE : S_IDLE;
          init_reply_d = 1'b0;
        end else begin
          k_d = k_q + 5'd1;
        end
      end
      S_AP_RD: begin
        i_raddr = sab_pkg::saddr(last_q);
        p_d     = last_q;
        state_d = S_AP_NEW;
      end
      S_AP_NEW: begin
        lennp_d = ir.len + LW'(1);
        np_d    = count_q + SW'(1);
        count_d = count_q + SW'(1);
        last_d  = count_q + SW'(1);
        i_we    = 1'b1;
        i_waddr = sab_pkg::saddr(count_q + SW'(1));
        i_wdata = '{len: ir.len + LW'(1), link: '0};
        k_d     = '0;
        state_d = S_AP_CLR;
      end
      S_AP_CLR: begin
        t_we    = 1'b1;
        t_waddr = sab_pkg::trow(np_q, k_q);
        if (k_q == 5'd0) begin
          // record the new state for this text position
          i_we    = 1'b1;
          i_waddr = sab_pkg::paddr(app_q[sab_pkg::POS_W-1:0]);
          i_wdata = '{len: '0, link: np_q};
          app_d   = app_q + LW'(1);
        end
        if (k_q == 5'(sab_pkg::ALPHABET - 1)) begin
          t_raddr = sab_pkg::trow(p_q, sym_q);
          i_raddr = sab_pkg::saddr(p_q);
          state_d = S_AP_W1;
        end else begin
          k_d = k_q + 5'd1;
        end
      end
      S_AP_W1: begin
        if (t_rdata == '0) begin
          t_we    = 1'b1;
          t_waddr = sab_pkg::trow(p_q, sym_q);
          t_wdata = np_q;
          if (ir.link == '0) begin
            i_we    = 1'b1;
            i_waddr = sab_pkg::saddr(np_q);
            i_wdata = '{len: lennp_q, link: SW'(1)};
            res_d   = '{state_id: 12'(np_q), state_longest: lennp_q, error: 1'b0};
            state_d = S_DONE;
          end else begin
            p_d     = ir.link;
            t_raddr = sab_pkg::trow(ir.link, sym_q);
            i_raddr = sab_pkg::saddr(ir.link);
          end
        end else begin
          q_d     = t_rdata;
          lenp_d  = ir.len;
          i_raddr = sab_pkg::saddr(t_rdata);
          state_d = S_AP_QCHK;
        end
      end
      S_AP_QCHK: begin
        if (ir.len == lenp_q + LW'(1)) begin
          i_we    = 1'b1;
          i_waddr = sab_pkg::saddr(np_q);
          i_wdata = '{len: lennp_q, link: q_q};
          res_d   = '{state_id: 12'(np_q), state_longest: lennp_q, error: 1'b0};
          state_d = S_DONE;
        end else begin
          // split: clone q with the shorter length
          nq_d    = count_q + SW'(1);
          count_d = count_q + SW'(1);
          i_we    = 1'b1;
          i_waddr = sab_pkg::saddr(count_q + SW'(1));
          i_wdata = '{len: lenp_q + LW'(1), link: ir.link};
          lenq_d  = ir.len;
          k_d     = '0;
          state_d = S_AP_COPY;
        end
      end
      S_AP_COPY: begin
        // read column k of q, write column k-1 of the clone in the next cycle
        if (k_q != 5'd0) begin
          t_we    = 1'b1;
          t_waddr = sab_pkg::trow(nq_q, k_q - 5'd1);
          t_wdata = t_rdata;
        end
        if (k_q == 5'd0) begin
          i_we    = 1'b1;
          i_waddr = sab_pkg::saddr(np_q);
          i_wdata = '{len: lennp_q, link: nq_q};
        end else if (k_q == 5'd1) begin
          i_we    = 1'b1;
          i_waddr = sab_pkg::saddr(q_q);
          i_wdata = '{len: lenq_q, link: nq_q};
        end
        if (k_q == 5'(sab_pkg::ALPHABET)) begin
          t_raddr = sab_pkg::trow(p_q, sym_q);
          i_raddr = sab_pkg::saddr(p_q);
          state_d = S_AP_W2;
        end else begin
          t_raddr = sab_pkg::trow(q_q, k_q);
          k_d     = k_q + 5'd1;
        end
      end
      S_AP_W2: begin
        if (t_rdata == q_q) begin
          t_we    = 1'b1;
          t_waddr = sab_pkg::trow(p_q, sym_q);
          t_wdata = nq_q;
          if (ir.link == '0) begin
            res_d   = '{state_id: 12'(np_q), state_longest: lennp_q, error: 1'b0};
            state_d = S_DONE;
          end else begin
            p_d     = ir.link;
            t_raddr = sab_pkg::trow(ir.link, sym_q);
            i_raddr = sab_pkg::saddr(ir.link);
          end
        end else begin
          res_d   = '{state_id: 12'(np_q), state_longest: lennp_q, error: 1'b0};
          state_d = S_DONE;
        end
      end
      S_LC_RD: begin
        i_raddr = sab_pkg::paddr(sab_pkg::POS_W'(endpos_q - 11'd1));
        state_d = S_LC_POS;
      end
      S_LC_POS: begin
        cur_d   = ir.link;
        i_raddr = sab_pkg::saddr(ir.link);
        state_d = (ir.link <= SW'(1)) ? S_LC_FIN : S_LC_CUR;
      end
      S_LC_CUR: begin
        link_d   = ir.link;
        curlen_d = ir.len;
        i_raddr  = sab_pkg::saddr(ir.link);
        state_d  = S_LC_CHK;
      end
      S_LC_CHK: begin
        // ir holds the link's entry: shortest length of cur is its longest plus one
        if (({1'b0, ir.len} + (LW+1)'(1)) <= (LW+1)'(sublen_q)) begin
          res_d   = '{state_id: 12'(cur_q), state_longest: curlen_q, error: 1'b0};
          state_d = S_DONE;
        end else begin
          cur_d   = link_q;
          i_raddr = sab_pkg::saddr(link_q);
          state_d = (link_q <= SW'(1)) ? S_LC_FIN : S_LC_CUR;
        end
      end
      S_LC_FIN: begin
        res_d   = '{state_id: 12'(cur_q), state_longest: ir.len, error: 1'b0};
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLR_ROOT;
      k_q          <= '0;
      last_q       <= SW'(1);
      count_q      <= SW'(1);
      app_q        <= '0;
      init_reply_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      k_q          <= k_d;
      last_q       <= last_d;
      count_q      <= count_d;
      app_q        <= app_d;
      init_reply_q <= init_reply_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q      <= p_d;
    np_q     <= np_d;
    q_q      <= q_d;
    nq_q     <= nq_d;
    cur_q    <= cur_d;
    link_q   <= link_d;
    lennp_q  <= lennp_d;
    lenp_q   <= lenp_d;
    lenq_q   <= lenq_d;
    curlen_q <= curlen_d;
    sym_q    <= sym_d;
    endpos_q <= endpos_d;
    sublen_q <= sublen_d;
    res_q    <= res_d;
    out_q    <= out_d;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### design/sab_ram.sv
`timescale 1ns / 1ps
// generic single-write, single-read synchronous ram with registered read data
module sab_ram #(
  parameter int DW    = 8,
  parameter int DEPTH = 256,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### design/sab_checker.sv
`timescale 1ns / 1ps
// port checker for the suffix automaton builder, bound to the top level
module sab_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_o,
  input sab_pkg::in_t  in_data_i,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input sab_pkg::out_t out_data_o
);

  // a stalled result word stays
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output word dropped or changed while stalled");

  // refused words carry no state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.error |->
      out_data_o.state_id == 12'd0 && out_data_o.state_longest == 11'd0)
    else $error("error word carries a state");

  // good words always name a real state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.error |-> out_data_o.state_id != 12'd0)
    else $error("good word with null state");

  // the root has length zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.error && out_data_o.state_id == 12'd1 |->
      out_data_o.state_longest == 11'd0)
    else $error("root reported with nonzero length");

endmodule

bind suffix_automaton_builder sab_checker u_sab_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .in_data_i  (in_data_i),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_data_o (out_data_o)
);
